### rtl/core/brp_pkg.sv
// brp_pkg: shared types and constants of the batch record parser.
// Stands alone; every other file in rtl/core refers to it by scoped names.

package brp_pkg;

	localparam int LENGTH_WIDTH_DEF = 32;
	localparam int VARINT_MAX_BYTES = 5;
	// 7 payload bits per varint byte
	localparam int VARINT_BITS      = 7 * VARINT_MAX_BYTES;

	localparam logic [7:0] CODE_PUT_RST          = 8'd1;
	localparam logic [7:0] CODE_DELETE_RST       = 8'd0;
	localparam logic [7:0] CODE_RANGE_DELETE_RST = 8'd15;

	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_KEYLEN = 3'd1,
		PH_KEY    = 3'd2,
		PH_VALLEN = 3'd3,
		PH_VAL    = 3'd4,
		PH_IGNORE = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_TYPE   = 3'd0,
		ROLE_KEYLEN = 3'd1,
		ROLE_KEY    = 3'd2,
		ROLE_VALLEN = 3'd3,
		ROLE_VAL    = 3'd4,
		ROLE_IGNORE = 3'd5
	} role_t;

	typedef enum logic [1:0] {
		KIND_PUT    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_RANGE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_TYPE  = 2'd1,
		ERR_VARINT    = 2'd2,
		ERR_TRUNCATED = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CFG_CODE_PUT          = 2'd0,
		CFG_CODE_DELETE       = 2'd1,
		CFG_CODE_RANGE_DELETE = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] byte_out;
		role_t      byte_role;
		kind_t      record_kind;
		logic       record_done;
		err_t       error_code;
	} out_word_t;

	typedef struct packed {
		logic [7:0] code_put;
		logic [7:0] code_delete;
		logic [7:0] code_range_delete;
	} cfg_codes_t;

endpackage

### rtl/core/brp_stream_if.sv
// Valid/ready stream interfaces of the batch record parser: raw bytes in,
// labelled bytes out. Payload types come from brp_pkg.

interface brp_byte_if ();
	logic              valid;
	logic              ready;
	brp_pkg::in_word_t word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

interface brp_label_if ();
	logic               valid;
	logic               ready;
	brp_pkg::out_word_t word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

### rtl/core/batch_record_parser.sv
// batch_record_parser: top level; input stage, parser and result register.
// Depends on brp_pkg, brp_stream_if.sv, brp_cfg_regs and brp_parser.
//
// Usage
//   raw_bytes carries one buffer byte per word (data_byte, buffer_end on the
//   final byte). labelled_bytes returns exactly one word per input word: the
//   byte, its role, the record kind, a record-done mark and an error code.
//   Both are valid/ready; a word moves on an edge with valid and ready high.
//   Type codes are set through cfg_we/cfg_index/cfg_data, index 0 put,
//   1 delete, 2 range delete; write them only while the block is empty.
// Timing
//   A word taken in is held in the input stage, labelled by the parser
//   and registered into the result stage when that stage is free or
//   draining. One word per cycle sustained while labelled_bytes is ready:
//   the input stage refills in the same cycle it drains, set by the
//   one-byte parser state update between the two registers.
// Reset and stalls
//   arst_n clears both stages, the parse state and sets the default codes.
//   When labelled_bytes stalls, the result holds, the input stage keeps
//   one word and raw_bytes.ready drops only once both are full.

module batch_record_parser #(
	parameter int LENGTH_WIDTH = brp_pkg::LENGTH_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	brp_byte_if.sink          raw_bytes,
	brp_label_if.source       labelled_bytes,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	// input stage
	logic               valid_s1;
	brp_pkg::in_word_t  word_s1;
	// result stage
	logic               valid_s2;
	brp_pkg::out_word_t word_s2;

	brp_pkg::cfg_codes_t codes;
	brp_pkg::out_word_t  result;
	logic                advance;
	logic                take_in;

	// word in stage 1 moves on when the result register is free or draining
	assign advance = valid_s1 && (!valid_s2 || labelled_bytes.ready);
	assign raw_bytes.ready = !valid_s1 || advance;
	assign take_in = raw_bytes.valid && raw_bytes.ready;

	brp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	brp_parser #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.in_word (word_s1),
		.codes   (codes),
		.result  (result)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= raw_bytes.word;
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (labelled_bytes.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= result;
		end
	end

	assign labelled_bytes.valid = valid_s2;
	assign labelled_bytes.word  = word_s2;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !labelled_bytes.ready |-> !advance)
		else $error("stalled result overwritten");

	a_stage1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("held input word lost");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("parsed word did not reach the result stage");
`endif

endmodule

### rtl/core/brp_cfg_regs.sv
// brp_cfg_regs: the three type-code registers and their write port.
// Uses brp_pkg for the register index codes and reset values.

module brp_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output brp_pkg::cfg_codes_t codes
);

	brp_pkg::cfg_codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.code_put          <= brp_pkg::CODE_PUT_RST;
			codes_q.code_delete       <= brp_pkg::CODE_DELETE_RST;
			codes_q.code_range_delete <= brp_pkg::CODE_RANGE_DELETE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				brp_pkg::CFG_CODE_PUT:          codes_q.code_put          <= cfg_data;
				brp_pkg::CFG_CODE_DELETE:       codes_q.code_delete       <= cfg_data;
				brp_pkg::CFG_CODE_RANGE_DELETE: codes_q.code_range_delete <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign codes = codes_q;

endmodule

### rtl/core/brp_parser.sv
// brp_parser: record parse state and the per-byte labelling logic.
// Uses brp_pkg types; state advances on step_en, result is combinational.

module brp_parser #(
	parameter int LENGTH_WIDTH = brp_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  brp_pkg::in_word_t   in_word,
	input  brp_pkg::cfg_codes_t codes,
	output brp_pkg::out_word_t  result
);

	localparam int VB = brp_pkg::VARINT_BITS;

	brp_pkg::phase_t         phase_q, phase_n;
	brp_pkg::kind_t          kind_q, kind_n;
	logic [LENGTH_WIDTH-1:0] accum_q, accum_n;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_n;
	logic [2:0]              cnt_q, cnt_n;

	logic [VB-1:0]           group_shifted;
	logic [LENGTH_WIDTH-1:0] accum_upd;
	logic [LENGTH_WIDTH-1:0] rem_dec;
	logic [2:0]              cnt_inc;
	logic                    is_key;

	brp_pkg::role_t role;
	brp_pkg::kind_t kind_out;
	brp_pkg::err_t  err;
	logic           done;

	// 7-bit group placed at 7 * count; count never exceeds 4 in a length phase
	assign group_shifted = VB'(in_word.data_byte[6:0]) << (6'(cnt_q) * 6'd7);
	assign accum_upd     = accum_q | group_shifted[LENGTH_WIDTH-1:0];
	assign cnt_inc       = cnt_q + 3'd1;
	assign rem_dec       = rem_q - LENGTH_WIDTH'(1);
	assign is_key        = (phase_q == brp_pkg::PH_KEYLEN) || (phase_q == brp_pkg::PH_KEY);

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		accum_n  = accum_q;
		rem_n    = rem_q;
		cnt_n    = cnt_q;
		role     = brp_pkg::ROLE_IGNORE;
		kind_out = brp_pkg::KIND_PUT;
		err      = brp_pkg::ERR_NONE;
		done     = 1'b0;

		case (phase_q)
			brp_pkg::PH_TYPE: begin
				role = brp_pkg::ROLE_TYPE;
				// put code wins over delete, delete over range delete
				if (in_word.data_byte == codes.code_put) begin
					kind_n = brp_pkg::KIND_PUT;
				end else if (in_word.data_byte == codes.code_delete) begin
					kind_n = brp_pkg::KIND_DELETE;
				end else if (in_word.data_byte == codes.code_range_delete) begin
					kind_n = brp_pkg::KIND_RANGE;
				end else begin
					err = brp_pkg::ERR_BAD_TYPE;
				end
				if (err == brp_pkg::ERR_NONE) begin
					kind_out = kind_n;
					phase_n  = brp_pkg::PH_KEYLEN;
					accum_n  = '0;
					cnt_n    = '0;
				end else begin
					kind_n  = kind_q;
					phase_n = brp_pkg::PH_IGNORE;
				end
			end
			brp_pkg::PH_KEYLEN, brp_pkg::PH_VALLEN: begin
				role     = is_key ? brp_pkg::ROLE_KEYLEN : brp_pkg::ROLE_VALLEN;
				kind_out = kind_q;
				accum_n  = accum_upd;
				cnt_n    = cnt_inc;
				if (in_word.data_byte[7]) begin
					if (cnt_inc >= 3'(brp_pkg::VARINT_MAX_BYTES)) begin
						err     = brp_pkg::ERR_VARINT;
						phase_n = brp_pkg::PH_IGNORE;
					end
				end else if (accum_upd != '0) begin
					rem_n   = accum_upd;
					phase_n = is_key ? brp_pkg::PH_KEY : brp_pkg::PH_VAL;
				end else if (is_key && kind_q != brp_pkg::KIND_DELETE) begin
					// empty key, value length follows
					phase_n = brp_pkg::PH_VALLEN;
					accum_n = '0;
					cnt_n   = '0;
				end else begin
					phase_n = brp_pkg::PH_TYPE;
					done    = 1'b1;
				end
			end
			brp_pkg::PH_KEY, brp_pkg::PH_VAL: begin
				role     = is_key ? brp_pkg::ROLE_KEY : brp_pkg::ROLE_VAL;
				kind_out = kind_q;
				rem_n    = rem_dec;
				if (rem_dec == '0) begin
					if (is_key && kind_q != brp_pkg::KIND_DELETE) begin
						phase_n = brp_pkg::PH_VALLEN;
						accum_n = '0;
						cnt_n   = '0;
					end else begin
						phase_n = brp_pkg::PH_TYPE;
						done    = 1'b1;
					end
				end
			end
			default: begin
				role = brp_pkg::ROLE_IGNORE;
			end
		endcase

		if (in_word.buffer_end) begin
			if (err == brp_pkg::ERR_NONE && !done && role != brp_pkg::ROLE_IGNORE) begin
				err = brp_pkg::ERR_TRUNCATED;
			end
			phase_n = brp_pkg::PH_TYPE;
			kind_n  = brp_pkg::KIND_PUT;
			accum_n = '0;
			rem_n   = '0;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= brp_pkg::PH_TYPE;
			kind_q  <= brp_pkg::KIND_PUT;
			accum_q <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			accum_q <= accum_n;
			rem_q   <= rem_n;
			cnt_q   <= cnt_n;
		end
	end

	assign result.byte_out    = in_word.data_byte;
	assign result.byte_role   = role;
	assign result.record_kind = kind_out;
	assign result.record_done = done;
	assign result.error_code  = err;

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && in_word.buffer_end |=> phase_q == brp_pkg::PH_TYPE && cnt_q == '0
			&& rem_q == '0)
		else $error("parse state not cleared after buffer end");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.record_done |-> result.error_code == brp_pkg::ERR_NONE)
		else $error("record marked done with an error");

	a_ignore_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.byte_role == brp_pkg::ROLE_IGNORE |-> result.record_kind == brp_pkg::KIND_PUT
			&& !result.record_done && result.error_code == brp_pkg::ERR_NONE)
		else $error("ignored byte carries labels");

	a_varint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == brp_pkg::PH_KEYLEN || phase_q == brp_pkg::PH_VALLEN)
			|-> cnt_q < 3'(brp_pkg::VARINT_MAX_BYTES))
		else $error("varint byte count out of range");

	a_field_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == brp_pkg::PH_KEY || phase_q == brp_pkg::PH_VAL) |-> rem_q != '0)
		else $error("key or value phase with nothing left");
`endif

endmodule
